FILE: design/stt_pkg.sv
`default_nettype none

package stt_pkg;

  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned MAX_RES    = 8;
  localparam int unsigned FIRE_W     = $clog2(MAX_RES + 1);

  typedef enum logic [1:0] {
    FUNC_REG   = 2'd0,
    FUNC_UNREG = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_REG   = 2'd0,
    KIND_UNREG = 2'd1,
    KIND_FIRE  = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [15:0] reload;
    logic        periodic;
    logic [7:0]  task_code;
    logic [31:0] handle;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  slot;
    logic        ok;
    logic [7:0]  task_code;
    logic [31:0] handle;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

FILE: design/stt_ram.sv
`default_nettype none

module stt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/software_timer_table_core.sv
`default_nettype none

// Software timer table with SlotCount slots. A register item takes the
// lowest free slot and answers with its number (ok 0 when the table is
// full); an unregister item frees a used slot. Both update the slot when
// accepted and then hold the block until the answer has moved on to the
// output. A tick item walks the slots one per cycle, pausing while a fire
// result waits on a held output, through a read-modify-write of the counter
// memory. Each expiring counter gives a fire result, up to MAX_RES per
// tick; the last result of an item carries last, so a fire result is kept
// back until the next one or the end of the walk. A new item is accepted
// once the previous item is done and at most one of its results still
// waits at the output.
module software_timer_table_core #(
  parameter int unsigned SlotCount = stt_pkg::SLOT_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] period_ticks_i,
  input  wire logic        repeat_mode_i,
  input  wire logic [7:0]  task_code_i,
  input  wire logic [31:0] user_handle_i,
  input  wire logic [2:0]  slot_sel_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [2:0]       slot_out_o,
  output logic             ok_o,
  output logic [7:0]       task_out_o,
  output logic [31:0]      handle_out_o,
  output logic             last_o
);

  localparam int unsigned SlotW = SlotCount > 1 ? $clog2(SlotCount) : 1;
  localparam int unsigned FireW = stt_pkg::FIRE_W;

  stt_pkg::state_e  state_q, state_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [FireW-1:0] fires_q, fires_d;
  logic [SlotCount-1:0] used_q, used_d;

  logic             pend_valid_q, pend_valid_d;
  stt_pkg::result_t pend_q, pend_new;
  logic             pend_load, pend_set_last, pend_move;
  logic             out_valid_q;
  stt_pkg::result_t out_q, out_new;

  logic             cnt_we, cfg_we;
  logic [SlotW-1:0] cnt_waddr, rd_addr;
  logic [15:0]      cnt_wdata, cnt_rd, dec;
  stt_pkg::cfg_t    cfg_wdata, cfg_rd;

  logic             have_free;
  logic [SlotW-1:0] free_idx, sel_idx;
  logic             in_range, in_fire;
  logic             fire_now, report, stall, is_last;

  stt_ram #(.Width(16), .Depth(SlotCount)) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(rd_addr),
    .rdata_o(cnt_rd)
  );

  stt_ram #(.Width($bits(stt_pkg::cfg_t)), .Depth(SlotCount)) u_cfg_ram (
    .clk_i  (clk_i),
    .we_i   (cfg_we),
    .waddr_i(free_idx),
    .wdata_i(cfg_wdata),
    .raddr_i(rd_addr),
    .rdata_o(cfg_rd)
  );

  assign in_ready_o = (state_q == stt_pkg::ST_IDLE) && !pend_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  // during a walk a fire result leaves only when the next one or the end comes
  assign pend_move  = pend_valid_q && (!out_valid_q || out_ready_i) &&
                      (state_q != stt_pkg::ST_SCAN || report || is_last);

  assign cfg_wdata.reload    = period_ticks_i;
  assign cfg_wdata.periodic  = repeat_mode_i;
  assign cfg_wdata.task_code = task_code_i;
  assign cfg_wdata.handle    = user_handle_i;

  assign in_range = {4'b0, slot_sel_i} < 7'(SlotCount);
  assign sel_idx  = SlotW'(slot_sel_i);

  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        have_free = 1'b1;
        free_idx  = SlotW'(i);
      end
    end
  end

  assign dec      = cnt_rd - 16'd1;
  assign is_last  = idx_q == SlotW'(SlotCount - 1);
  assign fire_now = used_q[idx_q] && (dec == 16'd0);
  assign report   = fire_now && (fires_q < FireW'(stt_pkg::MAX_RES));
  assign stall    = report && pend_valid_q && !pend_move;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    fires_d       = fires_q;
    used_d        = used_q;
    pend_valid_d  = pend_valid_q && !pend_move;
    pend_load     = 1'b0;
    pend_set_last = 1'b0;
    pend_new      = '0;
    cnt_we        = 1'b0;
    cnt_waddr     = idx_q;
    cnt_wdata     = dec;
    cfg_we        = 1'b0;
    rd_addr       = SlotW'(idx_q + 1'b1);
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (in_fire) begin
          unique case (stt_pkg::func_e'(func_i))
            stt_pkg::FUNC_REG: begin
              pend_load     = 1'b1;
              pend_valid_d  = 1'b1;
              pend_new.kind = stt_pkg::KIND_REG;
              pend_new.last = 1'b1;
              if (have_free) begin
                used_d[free_idx] = 1'b1;
                cnt_we           = 1'b1;
                cnt_waddr        = free_idx;
                cnt_wdata        = period_ticks_i;
                cfg_we           = 1'b1;
                pend_new.slot    = 3'(free_idx);
                pend_new.ok      = 1'b1;
              end
            end
            stt_pkg::FUNC_UNREG: begin
              pend_load     = 1'b1;
              pend_valid_d  = 1'b1;
              pend_new.kind = stt_pkg::KIND_UNREG;
              pend_new.slot = slot_sel_i;
              pend_new.last = 1'b1;
              if (in_range && used_q[sel_idx]) begin
                used_d[sel_idx] = 1'b0;
                pend_new.ok     = 1'b1;
              end
            end
            stt_pkg::FUNC_TICK: begin
              state_d = stt_pkg::ST_SCAN;
              idx_d   = '0;
              fires_d = '0;
            end
            stt_pkg::FUNC_NOP: begin
            end
          endcase
        end
      end
      stt_pkg::ST_SCAN: begin
        if (stall) begin
          rd_addr = idx_q;
        end else begin
          if (used_q[idx_q]) begin
            cnt_we = 1'b1;
            if (fire_now && cfg_rd.periodic) begin
              cnt_wdata = cfg_rd.reload;
            end
            if (fire_now && !cfg_rd.periodic) begin
              used_d[idx_q] = 1'b0;
            end
          end
          if (report) begin
            pend_load          = 1'b1;
            pend_valid_d       = 1'b1;
            pend_new.kind      = stt_pkg::KIND_FIRE;
            pend_new.slot      = 3'(idx_q);
            pend_new.ok        = 1'b1;
            pend_new.task_code = cfg_rd.task_code;
            pend_new.handle    = cfg_rd.handle;
            pend_new.last      = is_last;
            fires_d            = fires_q + 1'b1;
          end else if (is_last) begin
            pend_set_last = 1'b1;
          end
          if (is_last) begin
            state_d = stt_pkg::ST_IDLE;
          end else begin
            idx_d = SlotW'(idx_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = stt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_new      = pend_q;
    out_new.last = pend_q.last || pend_set_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= stt_pkg::ST_IDLE;
      idx_q        <= '0;
      fires_q      <= '0;
      used_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      fires_q      <= fires_d;
      used_q       <= used_d;
      pend_valid_q <= pend_valid_d;
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_q <= out_new;
    end
    if (pend_load) begin
      pend_q <= pend_new;
    end else if (pend_set_last) begin
      pend_q.last <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign slot_out_o   = out_q.slot;
  assign ok_o         = out_q.ok;
  assign task_out_o   = out_q.task_code;
  assign handle_out_o = out_q.handle;
  assign last_o       = out_q.last;

  a_pend_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !pend_move |=> pend_valid_q)
    else $error("pending result lost");

  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= FireW'(stt_pkg::MAX_RES))
    else $error("too many fire results");

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (func_i == stt_pkg::FUNC_TICK) |=> state_q == stt_pkg::ST_SCAN && idx_q == '0)
    else $error("tick scan did not start at slot zero");

  a_scan_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == stt_pkg::ST_SCAN |-> !in_fire)
    else $error("item accepted during scan");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 4 * stt_pkg::SLOT_COUNT;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i         = '0;
  logic [15:0] period_ticks_i = '0;
  logic        repeat_mode_i  = 1'b0;
  logic [7:0]  task_code_i    = '0;
  logic [31:0] user_handle_i  = '0;
  logic [2:0]  slot_sel_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [1:0]  kind_o;
  logic [2:0]  slot_out_o;
  logic        ok_o;
  logic [7:0]  task_out_o;
  logic [31:0] handle_out_o;
  logic        last_o;

  // timer table as the testbench sees it
  bit          slot_busy     [stt_pkg::SLOT_COUNT];
  logic [15:0] slot_reload   [stt_pkg::SLOT_COUNT];
  logic [15:0] slot_count    [stt_pkg::SLOT_COUNT];
  bit          slot_periodic [stt_pkg::SLOT_COUNT];
  logic [7:0]  slot_task     [stt_pkg::SLOT_COUNT];
  logic [31:0] slot_handle   [stt_pkg::SLOT_COUNT];

  stt_pkg::result_t pending_results[$];
  stt_pkg::result_t oldest_result;
  int unsigned error_count  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned rx_hold_left = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;

  always #6 clk_i = ~clk_i;

  software_timer_table_core #(
    .SlotCount(stt_pkg::SLOT_COUNT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .period_ticks_i(period_ticks_i),
    .repeat_mode_i (repeat_mode_i),
    .task_code_i   (task_code_i),
    .user_handle_i (user_handle_i),
    .slot_sel_i    (slot_sel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .slot_out_o    (slot_out_o),
    .ok_o          (ok_o),
    .task_out_o    (task_out_o),
    .handle_out_o  (handle_out_o),
    .last_o        (last_o)
  );

  function automatic void predict_timer_op(stt_pkg::func_e op, logic [15:0] period,
                                           logic rep, logic [7:0] tcode,
                                           logic [31:0] hnd, logic [2:0] sel);
    stt_pkg::result_t r;
    stt_pkg::result_t fired[$];
    int      found;
    r     = '0;
    found = -1;
    case (op)
      stt_pkg::FUNC_REG: begin
        for (int i = 0; i < stt_pkg::SLOT_COUNT; i++) begin
          if (!slot_busy[i] && found < 0) found = i;
        end
        r.kind = stt_pkg::KIND_REG;
        if (found >= 0) begin
          slot_busy[found]     = 1'b1;
          slot_reload[found]   = period;
          slot_count[found]    = period;
          slot_periodic[found] = rep;
          slot_task[found]     = tcode;
          slot_handle[found]   = hnd;
          r.slot = 3'(found);
          r.ok   = 1'b1;
        end
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      stt_pkg::FUNC_UNREG: begin
        r.kind = stt_pkg::KIND_UNREG;
        r.slot = sel;
        if (sel < stt_pkg::SLOT_COUNT && slot_busy[sel]) begin
          slot_busy[sel] = 1'b0;
          r.ok = 1'b1;
        end
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      stt_pkg::FUNC_TICK: begin
        for (int i = 0; i < stt_pkg::SLOT_COUNT; i++) begin
          if (slot_busy[i]) begin
            slot_count[i] = slot_count[i] - 16'd1;
            if (slot_count[i] == 16'd0) begin
              r           = '0;
              r.kind      = stt_pkg::KIND_FIRE;
              r.slot      = 3'(i);
              r.ok        = 1'b1;
              r.task_code = slot_task[i];
              r.handle    = slot_handle[i];
              if (fired.size() < stt_pkg::MAX_RES) fired.push_back(r);
              if (slot_periodic[i]) slot_count[i] = slot_reload[i];
              else slot_busy[i] = 1'b0;
            end
          end
        end
        if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
        foreach (fired[k]) pending_results.push_back(fired[k]);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(stt_pkg::func_e op, logic [15:0] period, logic rep,
                           logic [7:0] tcode, logic [31:0] hnd, logic [2:0] sel);
    if (!tx_calm && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= op;
    period_ticks_i <= period;
    repeat_mode_i  <= rep;
    task_code_i    <= tcode;
    user_handle_i  <= hnd;
    slot_sel_i     <= sel;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timer_op(op, period, rep, tcode, hnd, sel);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    stt_pkg::func_e op;
    logic [15:0] period;
    logic [2:0]  sel;
    int          pick;
    int          busy_list[$];
    pick   = $urandom_range(0, 99);
    period = 16'($urandom);
    if ($urandom_range(0, 9) != 0) period = 16'($urandom_range(1, 8));
    sel = 3'($urandom);
    for (int i = 0; i < stt_pkg::SLOT_COUNT; i++) begin
      if (slot_busy[i]) busy_list.push_back(i);
    end
    if (busy_list.size() > 0 && $urandom_range(0, 3) != 0)
      sel = 3'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
    if (pick < 30) op = stt_pkg::FUNC_REG;
    else if (pick < 45) op = stt_pkg::FUNC_UNREG;
    else if (pick < 95) op = stt_pkg::FUNC_TICK;
    else op = stt_pkg::FUNC_NOP;
    send_item(op, period, 1'($urandom), 8'($urandom), 32'($urandom), sel);
  endtask

  task automatic test_directed();
    send_item(stt_pkg::FUNC_REG, 16'd1, 1'b0, 8'hFF, 32'hFFFF_FFFF, 3'd7);
    send_item(stt_pkg::FUNC_REG, 16'd2, 1'b1, 8'h00, 32'h0000_0000, 3'd0);
    send_item(stt_pkg::FUNC_TICK, 16'hFFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF, 3'd7);
    send_item(stt_pkg::FUNC_TICK, 16'h0000, 1'b0, 8'h00, 32'h0000_0000, 3'd0);
    send_item(stt_pkg::FUNC_REG, 16'hFFFF, 1'b1, 8'hA5, 32'h8000_0001, 3'd0);
    // six more fit, the seventh finds the table full
    for (int i = 0; i < 7; i++)
      send_item(stt_pkg::FUNC_REG, 16'd3, 1'(i), 8'(8'h11 * i), 32'h1357_9BDF << i,
                3'(i));
    send_item(stt_pkg::FUNC_UNREG, 16'h0, 1'b0, 8'h0, 32'h0, 3'd7);
    send_item(stt_pkg::FUNC_UNREG, 16'h0, 1'b0, 8'h0, 32'h0, 3'd7);
    send_item(stt_pkg::FUNC_NOP, 16'hFFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF, 3'd7);
    repeat (3) send_item(stt_pkg::FUNC_TICK, 16'h0, 1'b0, 8'h0, 32'h0, 3'd0);
    for (int i = 0; i < stt_pkg::SLOT_COUNT; i++)
      send_item(stt_pkg::FUNC_UNREG, 16'h0, 1'b0, 8'h0, 32'h0, 3'(i));
    // empty table
    send_item(stt_pkg::FUNC_TICK, 16'h0, 1'b0, 8'h0, 32'h0, 3'd0);
  endtask

  task automatic test_zero_period_wrap();
    wait_for_results();
    send_item(stt_pkg::FUNC_REG, 16'h0000, 1'b0, 8'h3C, 32'hDEAD_BEEF, 3'd0);
    send_item(stt_pkg::FUNC_REG, 16'hFFFF, 1'b1, 8'hC3, 32'h0BAD_F00D, 3'd0);
    // the zero period wraps on the first tick, so neither timer fires here
    repeat (4) send_item(stt_pkg::FUNC_TICK, 16'h0, 1'b0, 8'h0, 32'h0, 3'd0);
    send_item(stt_pkg::FUNC_UNREG, 16'h0, 1'b0, 8'h0, 32'h0, 3'd1);
    send_item(stt_pkg::FUNC_UNREG, 16'h0, 1'b0, 8'h0, 32'h0, 3'd0);
  endtask

  task automatic test_backpressure();
    wait_for_results();
    @(posedge clk_i);
    rx_hold_left <= 300;
    for (int i = 0; i < stt_pkg::SLOT_COUNT; i++)
      send_item(stt_pkg::FUNC_REG, 16'd1, 1'b1, 8'(i + 1), 32'($urandom), 3'(i));
    repeat (6) send_item(stt_pkg::FUNC_TICK, 16'h0, 1'b0, 8'h0, 32'h0, 3'd0);
    for (int i = 0; i < stt_pkg::SLOT_COUNT; i++)
      send_item(stt_pkg::FUNC_UNREG, 16'h0, 1'b0, 8'h0, 32'h0, 3'(i));
    wait_for_results();
  endtask

  task automatic test_calm_stream();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (90) send_random_item();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_random();
    for (int n = 0; n < 215; n++) begin
      send_random_item();
      if (n % 60 == 59) wait_for_results();
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_ready_i  <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ready_i <= rx_calm || ($urandom_range(0, 99) >= 8);
    end
  end

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: kind %0d slot %0d", kind_o, slot_out_o);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("kind", 32'(oldest_result.kind), 32'(kind_o));
        check_field("slot_out", 32'(oldest_result.slot), 32'(slot_out_o));
        check_field("ok", 32'(oldest_result.ok), 32'(ok_o));
        check_field("task_out", 32'(oldest_result.task_code), 32'(task_out_o));
        check_field("handle_out", oldest_result.handle, handle_out_o);
        check_field("last", 32'(oldest_result.last), 32'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_period_wrap();
    test_backpressure();
    test_calm_stream();
    test_random();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
